@@ rtl/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types and constants for the ranging controller.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int TICK_W  = 16;
   localparam int CHAN_W  = 4;
   localparam int DIST_W  = 19;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0] TRIGGER_TICKS = 16'd10;

   // 0.0343 / 2 * 256 cm per tick with a 10-bit fraction.
   localparam int DIST_MULT  = 4496;
   localparam int DIST_SHIFT = 10;
   localparam logic [DIST_W-1:0] DIST_MAX = 19'h7FFFF;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 2'd2;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 16'd25000;
   localparam logic [DIST_W-1:0] MIN_DIST_RESET = 19'd512;
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = 19'd102400;

   // Range status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_BELOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_ABOVE = 2'd2;

   typedef struct packed {
      logic              start_req;
      logic [CHAN_W-1:0] trigger_channel;
      logic [CHAN_W-1:0] echo_channel;
      logic              echo_level;
   } req_item_type;

   // One tick's control outputs plus the raw pulse width for ranging.
   typedef struct packed {
      logic              trigger_level;
      logic              pin_is_output;
      logic [CHAN_W-1:0] mux_address;
      logic              busy_res;
      logic              done_res;
      logic [TICK_W-1:0] width;
   } tick_type;

   typedef struct packed {
      logic              trigger_level;
      logic              pin_is_output;
      logic [CHAN_W-1:0] mux_address;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] distance;
      logic [STAT_W-1:0] range_status;
   } rsp_item_type;

endpackage

@@ rtl/uer_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger sequencer
// Steps the trigger / wait / measure sequence once per tick word and
// registers the tick's control outputs together with the pulse width.
// ----------------------------------------------------------------------------
module uer_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  uer_pkg::req_item_type         in_item,
   output logic                          take,
   input  logic [uer_pkg::TICK_W-1:0]    timeout_ticks,
   output logic                          mid_valid,
   output uer_pkg::tick_type             mid_item,
   input  logic                          mid_ready
);
   import uer_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRIG = 2'd1;
   localparam logic [1:0] PH_WAIT = 2'd2;
   localparam logic [1:0] PH_MEAS = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic [TICK_W-1:0] rise_ff, rise_in;
   logic [CHAN_W-1:0] held_trig_ff, held_trig_in;
   logic [CHAN_W-1:0] held_echo_ff, held_echo_in;
   logic              mid_valid_ff, mid_valid_in;
   tick_type          mid_ff, mid_in;
   logic              stage_ready;
   logic [TICK_W-1:0] elapsed_inc;
   logic              timed_out;

   assign stage_ready = !mid_valid_ff || mid_ready;
   assign take        = in_valid && stage_ready;
   assign elapsed_inc = elapsed_ff + 1'b1;
   assign timed_out   = (elapsed_ff >= timeout_ticks);

   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      rise_in      = rise_ff;
      held_trig_in = held_trig_ff;
      held_echo_in = held_echo_ff;

      mid_in.trigger_level = 1'b0;
      mid_in.pin_is_output = 1'b0;
      mid_in.mux_address   = held_echo_ff;
      mid_in.busy_res      = 1'b0;
      mid_in.done_res      = 1'b0;
      mid_in.width         = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (in_item.start_req) begin
               held_trig_in         = in_item.trigger_channel;
               held_echo_in         = in_item.echo_channel;
               phase_in             = PH_TRIG;
               elapsed_in           = TICK_W'(1);
               mid_in.trigger_level = 1'b1;
               mid_in.pin_is_output = 1'b1;
               mid_in.mux_address   = in_item.trigger_channel;
               mid_in.busy_res      = 1'b1;
            end
         end
         PH_TRIG: begin
            mid_in.trigger_level = 1'b1;
            mid_in.pin_is_output = 1'b1;
            mid_in.mux_address   = held_trig_ff;
            mid_in.busy_res      = 1'b1;
            if (elapsed_inc >= TRIGGER_TICKS) begin
               phase_in   = PH_WAIT;
               elapsed_in = '0;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
         PH_WAIT: begin
            if (timed_out) begin
               mid_in.done_res = 1'b1;
               phase_in        = PH_IDLE;
               elapsed_in      = '0;
            end else if (in_item.echo_level) begin
               mid_in.busy_res = 1'b1;
               rise_in         = elapsed_ff;
               phase_in        = PH_MEAS;
            end else begin
               mid_in.busy_res = 1'b1;
               elapsed_in      = elapsed_inc;
            end
         end
         PH_MEAS: begin
            if (!in_item.echo_level || timed_out) begin
               mid_in.done_res = 1'b1;
               mid_in.width    = elapsed_ff - rise_ff;
               phase_in        = PH_IDLE;
               elapsed_in      = '0;
            end else begin
               mid_in.busy_res = 1'b1;
               elapsed_in      = elapsed_inc;
            end
         end
      endcase
   end

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (take) begin
         mid_valid_in = 1'b1;
      end else if (mid_ready) begin
         mid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         rise_ff      <= '0;
         held_trig_ff <= '0;
         held_echo_ff <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         if (take) begin
            phase_ff     <= phase_in;
            elapsed_ff   <= elapsed_in;
            rise_ff      <= rise_in;
            held_trig_ff <= held_trig_in;
            held_echo_ff <= held_echo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_item  = mid_ff;

   // The trigger pulse count never reaches its end value while in the pulse.
   a_trig_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRIG |-> elapsed_ff < TRIGGER_TICKS)
      else $error("trigger count out of range");

   // A start taken in idle always begins the trigger pulse.
   a_start: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_IDLE && in_item.start_req |=> phase_ff == PH_TRIG)
      else $error("start did not enter trigger phase");

   // Sequencer state only moves when a tick word is consumed.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(phase_ff) && $stable(elapsed_ff))
      else $error("sequencer advanced without a tick");

   // A finished measurement is never reported as busy or triggering.
   a_done: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && mid_ff.done_res |-> !mid_ff.busy_res && !mid_ff.trigger_level)
      else $error("done tick flagged busy");
endmodule

@@ rtl/uer_range.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger distance stage
// Converts the pulse width to 1/256 cm, checks the limits and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module uer_range #(
   parameter int WIDTH_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mid_valid,
   input  uer_pkg::tick_type             mid_item,
   output logic                          mid_ready,
   input  logic [uer_pkg::DIST_W-1:0]    min_distance,
   input  logic [uer_pkg::DIST_W-1:0]    max_distance,
   output logic                          rsp_valid,
   output uer_pkg::rsp_item_type         rsp_item,
   input  logic                          rsp_ready
);
   import uer_pkg::*;

   // The raw width is a tick count, so only its low bits can survive the mask.
   localparam int KW     = (WIDTH_BITS < TICK_W) ? WIDTH_BITS : TICK_W;
   localparam int PROD_W = KW + 13;

   logic [KW-1:0]     width_kept;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] dist_full;
   logic [DIST_W-1:0] dist_sat;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_ff, out_in;

   assign width_kept = mid_item.width[KW-1:0];
   assign product    = PROD_W'(width_kept) * PROD_W'(DIST_MULT);
   assign dist_full  = product >> DIST_SHIFT;
   assign dist_sat   = (dist_full > PROD_W'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];

   assign mid_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      out_in.trigger_level = mid_item.trigger_level;
      out_in.pin_is_output = mid_item.pin_is_output;
      out_in.mux_address   = mid_item.mux_address;
      out_in.busy_res      = mid_item.busy_res;
      out_in.done_res      = mid_item.done_res;
      out_in.distance      = '0;
      out_in.range_status  = ST_OK;
      if (mid_item.done_res) begin
         out_in.distance = dist_sat;
         if (dist_sat < min_distance) begin
            out_in.range_status = ST_BELOW;
         end else if (dist_sat > max_distance) begin
            out_in.range_status = ST_ABOVE;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (mid_valid && mid_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_valid && mid_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // Only a done tick carries a distance and a status.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.done_res |-> out_ff.distance == '0 && out_ff.range_status == ST_OK)
      else $error("result fields set without done");

   // A below-minimum status always matches the stored distance.
   a_below: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.range_status == ST_BELOW |-> out_ff.distance < min_distance)
      else $error("below status inconsistent with distance");

   // A stalled result word is not overwritten.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");
endmodule

@@ rtl/ultrasonic_echo_ranger_top.sv @@
// Each accepted tick word yields one result word, after the sequencer and distance stages.
// Throughput: one tick word per cycle while the result side is ready, set by the single-pass sequencer step.
// Pipeline is input register, sequencer register, distance/output register.
// Reset clears the sequencer to idle with zero counters and channels.
// Reset loads timeout 25000, minimum 512 and maximum 102400 into the registers.
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger top level
// Trigger pulse generation, echo timing and distance checking per tick word.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top #(
   parameter int WIDTH_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, from bit 0: start_req, trigger_channel[3:0], echo_channel[3:0],
   // echo_level, zero fill.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,
   // rsp_tdata, from bit 0: trigger_level, pin_is_output, mux_address[3:0],
   // busy_res, done_res, distance[18:0], range_status[1:0], zero fill.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [uer_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uer_pkg::DIST_W-1:0]        csr_data
);
   import uer_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_item_type      in_ff;
   logic              take;
   logic [TICK_W-1:0] timeout_ff;
   logic [DIST_W-1:0] min_dist_ff;
   logic [DIST_W-1:0] max_dist_ff;
   logic              mid_valid;
   tick_type          mid_item;
   logic              mid_ready;
   rsp_item_type      rsp_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         min_dist_ff <= MIN_DIST_RESET;
         max_dist_ff <= MAX_DIST_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT:  timeout_ff  <= csr_data[TICK_W-1:0];
            CSR_MIN_DIST: min_dist_ff <= csr_data;
            CSR_MAX_DIST: max_dist_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.start_req       <= req_tdata[0];
         in_ff.trigger_channel <= req_tdata[4:1];
         in_ff.echo_channel    <= req_tdata[8:5];
         in_ff.echo_level      <= req_tdata[9];
      end
   end

   uer_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (in_valid_ff),
      .in_item       (in_ff),
      .take          (take),
      .timeout_ticks (timeout_ff),
      .mid_valid     (mid_valid),
      .mid_item      (mid_item),
      .mid_ready     (mid_ready)
   );

   uer_range #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_range (
      .clock        (clock),
      .reset        (reset),
      .mid_valid    (mid_valid),
      .mid_item     (mid_item),
      .mid_ready    (mid_ready),
      .min_distance (min_dist_ff),
      .max_distance (max_dist_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_item     (rsp_item),
      .rsp_ready    (rsp_tready)
   );

   assign rsp_tdata = {3'b000,
                       rsp_item.range_status,
                       rsp_item.distance,
                       rsp_item.done_res,
                       rsp_item.busy_res,
                       rsp_item.mux_address,
                       rsp_item.pin_is_output,
                       rsp_item.trigger_level};
endmodule

@@ dv/ultrasonic_echo_ranger_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives one tick word per handshake and predicts every result word. The run
// opens with a short directed sequence, then walks a series of timeout and
// distance limit settings, including the zero and maximum timeout. Random
// ranging cycles make up most of the traffic. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top_tb;
   import uer_pkg::*;

   localparam int PULSE_W        = 16;
   localparam int PLAN_ROWS      = 19;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;

   typedef enum logic [1:0] {
      RG_IDLE,
      RG_TRIGGER,
      RG_WAIT_RISE,
      RG_MEASURE
   } ranger_phase_type;

   typedef struct packed {
      req_item_type stim;
      logic         typed;
      rsp_item_type want;
   } plan_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DIST_W-1:0]    csr_data   = '0;

   // Predictor state and its copy of the configuration registers.
   ranger_phase_type  rg_phase     = RG_IDLE;
   logic [TICK_W-1:0] rg_elapsed   = '0;
   logic [TICK_W-1:0] rg_rise      = '0;
   logic [CHAN_W-1:0] rg_trig_chan = '0;
   logic [CHAN_W-1:0] rg_echo_chan = '0;
   logic [TICK_W-1:0] cfg_timeout  = TIMEOUT_RESET;
   logic [DIST_W-1:0] cfg_min      = MIN_DIST_RESET;
   logic [DIST_W-1:0] cfg_max      = MAX_DIST_RESET;

   rsp_item_type predicted_readings [$];
   plan_row_type tick_plan [PLAN_ROWS];

   // Typed expectation that travels with the word currently offered.
   logic         offer_typed = 1'b0;
   rsp_item_type offer_want  = '0;

   int          mismatch_count = 0;
   int unsigned results_taken  = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned burst_left     = 0;

   ultrasonic_echo_ranger_top #(
      .WIDTH_BITS (PULSE_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the predicted sequencer by one tick and returns that tick's result.
   function automatic rsp_item_type range_tick(req_item_type it);
      rsp_item_type      r;
      logic [TICK_W-1:0] pulse;
      logic [31:0]       scaled;
      logic              finish_now;
      r             = '0;
      r.mux_address = rg_echo_chan;
      pulse         = '0;
      finish_now    = 1'b0;
      case (rg_phase)
         RG_IDLE: begin
            if (it.start_req) begin
               rg_trig_chan    = it.trigger_channel;
               rg_echo_chan    = it.echo_channel;
               rg_phase        = RG_TRIGGER;
               rg_elapsed      = TICK_W'(1);
               r.trigger_level = 1'b1;
               r.pin_is_output = 1'b1;
               r.mux_address   = it.trigger_channel;
               r.busy_res      = 1'b1;
            end
         end
         RG_TRIGGER: begin
            r.trigger_level = 1'b1;
            r.pin_is_output = 1'b1;
            r.mux_address   = rg_trig_chan;
            r.busy_res      = 1'b1;
            rg_elapsed      = rg_elapsed + 1'b1;
            if (rg_elapsed >= TRIGGER_TICKS) begin
               rg_phase   = RG_WAIT_RISE;
               rg_elapsed = '0;
            end
         end
         RG_WAIT_RISE: begin
            r.busy_res = 1'b1;
            // The timeout wins over an echo that rises on the same tick.
            if (rg_elapsed >= cfg_timeout) begin
               finish_now = 1'b1;
            end else if (it.echo_level) begin
               rg_rise  = rg_elapsed;
               rg_phase = RG_MEASURE;
            end else begin
               rg_elapsed = rg_elapsed + 1'b1;
            end
         end
         default: begin
            r.busy_res = 1'b1;
            if (!it.echo_level || rg_elapsed >= cfg_timeout) begin
               finish_now = 1'b1;
               pulse      = rg_elapsed - rg_rise;
            end else begin
               rg_elapsed = rg_elapsed + 1'b1;
            end
         end
      endcase
      if (finish_now) begin
         scaled = (32'(pulse) * DIST_MULT) >> DIST_SHIFT;
         if (scaled > DIST_MAX) begin
            scaled = 32'(DIST_MAX);
         end
         r.busy_res   = 1'b0;
         r.done_res   = 1'b1;
         r.distance   = scaled[DIST_W-1:0];
         if (r.distance < cfg_min) begin
            r.range_status = ST_BELOW;
         end else if (r.distance > cfg_max) begin
            r.range_status = ST_ABOVE;
         end else begin
            r.range_status = ST_OK;
         end
         rg_phase   = RG_IDLE;
         rg_elapsed = '0;
      end
      return r;
   endfunction

   function automatic req_item_type noise_tick();
      req_item_type it;
      it.start_req       = 1'($urandom_range(0, 1));
      it.trigger_channel = 4'($urandom_range(0, 15));
      it.echo_channel    = 4'($urandom_range(0, 15));
      it.echo_level      = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Offers one tick word, waits for it to be taken, then applies the burst
   // and gap pattern of the sender.
   task automatic send_tick(req_item_type it, logic typed, rsp_item_type want);
      int unsigned gap;
      req_tdata   <= {6'b0, it.echo_level, it.echo_channel, it.trigger_channel,
                      it.start_req};
      offer_typed <= typed;
      offer_want  <= want;
      req_tvalid  <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Brings the sequencer back to idle with quiet ticks and waits until every
   // predicted result word has come back.
   task automatic settle_idle();
      req_item_type it;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rg_phase != RG_IDLE) begin
         it            = noise_tick();
         it.start_req  = 1'b0;
         it.echo_level = 1'b0;
         send_tick(it, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_readings.size() != 0) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] idx, logic [DIST_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(logic [TICK_W-1:0] ticks, logic [DIST_W-1:0] lo,
                                logic [DIST_W-1:0] hi);
      settle_idle();
      put_reg(CSR_TIMEOUT, DIST_W'(ticks));
      put_reg(CSR_MIN_DIST, lo);
      put_reg(CSR_MAX_DIST, hi);
      csr_valid   <= 1'b0;
      cfg_timeout  = ticks;
      cfg_min      = lo;
      cfg_max      = hi;
   endtask

   // One ranging cycle: start, trigger pulse, low wait, echo high, falling
   // edge. Stray start requests land on the busy ticks when asked for.
   task automatic run_ranging(int unsigned low_len, int unsigned high_len,
                              logic stray_starts);
      req_item_type it;
      int unsigned  k;
      it           = noise_tick();
      it.start_req = 1'b1;
      send_tick(it, 1'b0, '0);
      for (k = 0; k < 9; k++) begin
         send_tick(noise_tick(), 1'b0, '0);
      end
      for (k = 0; k < low_len + high_len; k++) begin
         it            = noise_tick();
         it.start_req  = stray_starts && ($urandom_range(0, 7) == 0);
         it.echo_level = (k >= low_len);
         send_tick(it, 1'b0, '0);
      end
      // Falling edge; a start here hits the done tick and must be ignored.
      it            = noise_tick();
      it.echo_level = 1'b0;
      send_tick(it, 1'b0, '0);
   endtask

   task automatic random_ranging(int unsigned limit);
      req_item_type it;
      int unsigned  cap;
      int unsigned  lead;
      int unsigned  k;
      cap  = (cfg_timeout + 2 < limit) ? cfg_timeout + 2 : limit;
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      for (k = 0; k < lead; k++) begin
         it           = noise_tick();
         it.start_req = 1'b0;
         send_tick(it, 1'b0, '0);
      end
      run_ranging($urandom_range(0, cap),
                  ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, cap), 1'b1);
   endtask

   // Result checking and prediction at each accepted word.
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      rsp_item_type predicted;
      req_item_type taken;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_taken++;
            seen.trigger_level = rsp_tdata[0];
            seen.pin_is_output = rsp_tdata[1];
            seen.mux_address   = rsp_tdata[5:2];
            seen.busy_res      = rsp_tdata[6];
            seen.done_res      = rsp_tdata[7];
            seen.distance      = rsp_tdata[26:8];
            seen.range_status  = rsp_tdata[28:27];
            if (predicted_readings.size() == 0) begin
               $error("result word %h arrived with no prediction waiting", rsp_tdata);
               mismatch_count++;
            end else begin
               want = predicted_readings.pop_front();
               compare_field("trigger_level", want.trigger_level, seen.trigger_level);
               compare_field("pin_is_output", want.pin_is_output, seen.pin_is_output);
               compare_field("mux_address", want.mux_address, seen.mux_address);
               compare_field("busy_res", want.busy_res, seen.busy_res);
               compare_field("done_res", want.done_res, seen.done_res);
               compare_field("distance", want.distance, seen.distance);
               compare_field("range_status", want.range_status, seen.range_status);
               compare_field("zero_fill", 0, rsp_tdata[31:29]);
            end
         end
         if (req_tvalid && req_tready) begin
            taken.start_req       = req_tdata[0];
            taken.trigger_channel = req_tdata[4:1];
            taken.echo_channel    = req_tdata[8:5];
            taken.echo_level      = req_tdata[9];
            predicted = range_tick(taken);
            predicted_readings.push_back(offer_typed ? offer_want : predicted);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: stall patterns that change over random spans, and one
   // long hold-off so the pipeline fills and back-pressures the tick input.
   initial begin
      int unsigned span;
      int unsigned mode;
      logic        long_hold_done;
      span           = 0;
      mode           = 0;
      long_hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!long_hold_done && results_taken >= 900) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(16, 160);
            end
            span--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   initial begin
      int r;
      req_item_type close_it;
      // Default limits: a two-tick echo gives distance 8, below the minimum.
      tick_plan[0]  = '{'{1'b0, 4'd5,  4'd5,  1'b1}, 1'b1, '0};
      tick_plan[1]  = '{'{1'b1, 4'd15, 4'd0,  1'b0}, 1'b1,
                        '{1'b1, 1'b1, 4'd15, 1'b1, 1'b0, 19'd0, ST_OK}};
      tick_plan[2]  = '{'{1'b1, 4'd0,  4'd15, 1'b1}, 1'b0, '0};
      tick_plan[3]  = '{'{1'b0, 4'd10, 4'd5,  1'b0}, 1'b0, '0};
      tick_plan[4]  = '{'{1'b1, 4'd5,  4'd10, 1'b1}, 1'b0, '0};
      tick_plan[5]  = '{'{1'b0, 4'd15, 4'd15, 1'b0}, 1'b0, '0};
      tick_plan[6]  = '{'{1'b1, 4'd0,  4'd0,  1'b1}, 1'b0, '0};
      tick_plan[7]  = '{'{1'b0, 4'd3,  4'd12, 1'b1}, 1'b0, '0};
      tick_plan[8]  = '{'{1'b1, 4'd12, 4'd3,  1'b0}, 1'b0, '0};
      tick_plan[9]  = '{'{1'b0, 4'd6,  4'd9,  1'b1}, 1'b0, '0};
      tick_plan[10] = '{'{1'b1, 4'd9,  4'd6,  1'b0}, 1'b0, '0};
      tick_plan[11] = '{'{1'b0, 4'd1,  4'd2,  1'b0}, 1'b0, '0};
      tick_plan[12] = '{'{1'b1, 4'd2,  4'd1,  1'b0}, 1'b0, '0};
      tick_plan[13] = '{'{1'b0, 4'd0,  4'd0,  1'b1}, 1'b0, '0};
      tick_plan[14] = '{'{1'b1, 4'd15, 4'd15, 1'b1}, 1'b0, '0};
      tick_plan[15] = '{'{1'b0, 4'd7,  4'd8,  1'b1}, 1'b0, '0};
      tick_plan[16] = '{'{1'b1, 4'd8,  4'd7,  1'b0}, 1'b1,
                        '{1'b0, 1'b0, 4'd0, 1'b0, 1'b1, 19'd8, ST_BELOW}};
      tick_plan[17] = '{'{1'b0, 4'd0,  4'd0,  1'b1}, 1'b1, '0};
      tick_plan[18] = '{'{1'b1, 4'd0,  4'd15, 1'b1}, 1'b1,
                        '{1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 19'd0, ST_OK}};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < PLAN_ROWS; r++) begin
         send_tick(tick_plan[r].stim, tick_plan[r].typed, tick_plan[r].want);
      end
      // The last directed start ends with a one-tick echo right after the
      // trigger pulse, which gives a zero width.
      for (r = 0; r < 11; r++) begin
         close_it            = '0;
         close_it.echo_level = (r == 9);
         send_tick(close_it, 1'b0, '0);
      end
      settle_idle();
      repeat (3) random_ranging(40);

      apply_setting(16'd0, 19'd0, 19'd0);
      repeat (6) random_ranging(40);

      apply_setting(16'd1, 19'd287744, 19'd287744);
      repeat (6) random_ranging(40);

      // Echo held high from the first wait tick under the longest timeout.
      apply_setting(16'd65535, 19'd0, 19'd287744);
      run_ranging(0, 120, 1'b0);
      repeat (3) random_ranging(40);

      for (r = 0; r < 5; r++) begin
         apply_setting(16'($urandom_range(2, 60)), 19'($urandom_range(0, 300)),
                       19'($urandom_range(0, 300)));
         repeat (3) random_ranging(40);
      end

      apply_setting(16'd250, 19'($urandom_range(0, 600)),
                    19'($urandom_range(262144, 287744)));
      repeat (2) random_ranging(120);

      settle_idle();
      repeat (8) @(posedge clock);
      if (predicted_readings.size() != 0) begin
         $error("%0d predicted result words never arrived", predicted_readings.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
